>>> rtl/q2e_pkg.sv
// shared types, constants and helpers for the quaternion to euler angle unit
// no dependencies
package q2e_pkg;

  // number of arctangent cells, capped by the angle table length
  localparam int CORDIC_STEPS = 16;
  localparam int AtanTableLen = 24;
  localparam int CordicLen    = (CORDIC_STEPS > AtanTableLen) ? AtanTableLen : CORDIC_STEPS;

  // square root: one result bit per cell, 29 result bits for a Q56 operand
  localparam int SqrtSteps = 29;
  localparam int SqW       = 58;
  localparam int RootW     = 29;

  // datapath widths
  localparam int ProdW = 32;   // 16 x 16 signed product
  localparam int SumW  = 34;   // doubled sum of two products
  localparam int SinW  = 30;   // arcsine argument clamped to +-2^28
  localparam int XW    = 37;   // arctangent vector components
  localparam int AW    = 26;   // angle in 1/65536 degree
  localparam int OutW  = 17;   // rounded angle in 1/128 degree

  localparam logic signed [SumW-1:0] OneQ28 = SumW'(64'sd268435456);
  localparam logic signed [SinW-1:0] SinMax = SinW'(64'sd268435456);
  localparam logic signed [SinW-1:0] SinMin = SinW'(-64'sd268435456);
  localparam logic signed [AW-1:0]   Deg90  = AW'(64'sd5898240);
  localparam logic [SqW-1:0]         OneQ56 = SqW'(64'h0100_0000_0000_0000);

  localparam logic signed [OutW-1:0] LimWide   = OutW'(64'sd23040);
  localparam logic signed [OutW-1:0] LimNarrow = OutW'(64'sd11520);

  // arctangent vector with its accumulated angle
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 frozen;
  } cordic_t;

  // square root working set
  typedef struct packed {
    logic [SqW-1:0] n;
    logic [SqW-1:0] r;
    logic [SqW-1:0] bm;
  } sqrt_t;

  // operands carried alongside the square root
  typedef struct packed {
    logic signed [SumW-1:0] rn;
    logic signed [SumW-1:0] rd;
    logic signed [SumW-1:0] yn;
    logic signed [SumW-1:0] yd;
    logic signed [SinW-1:0] s;
    logic                   sat_pos;
    logic                   sat_neg;
  } ctx_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [AW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      5'd0:  v = AW'(64'sd2949120);
      5'd1:  v = AW'(64'sd1740967);
      5'd2:  v = AW'(64'sd919879);
      5'd3:  v = AW'(64'sd466945);
      5'd4:  v = AW'(64'sd234379);
      5'd5:  v = AW'(64'sd117304);
      5'd6:  v = AW'(64'sd58666);
      5'd7:  v = AW'(64'sd29335);
      5'd8:  v = AW'(64'sd14668);
      5'd9:  v = AW'(64'sd7334);
      5'd10: v = AW'(64'sd3667);
      5'd11: v = AW'(64'sd1833);
      5'd12: v = AW'(64'sd917);
      5'd13: v = AW'(64'sd458);
      5'd14: v = AW'(64'sd229);
      5'd15: v = AW'(64'sd115);
      5'd16: v = AW'(64'sd57);
      5'd17: v = AW'(64'sd29);
      5'd18: v = AW'(64'sd14);
      5'd19: v = AW'(64'sd7);
      5'd20: v = AW'(64'sd4);
      5'd21: v = AW'(64'sd2);
      5'd22: v = AW'(64'sd1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // round to 1/128 degree (half up) and clamp to +-lim
  function automatic logic signed [OutW-1:0] round_angle(input logic signed [AW-1:0] ang,
                                                        input logic signed [OutW-1:0] lim);
    logic signed [AW:0]     sum;
    logic signed [OutW-1:0] d;
    sum = (AW+1)'(ang) + (AW+1)'(256);
    d   = OutW'(sum >>> 9);
    if (d > lim) begin
      d = lim;
    end else if (d < -lim) begin
      d = -lim;
    end
    return d;
  endfunction

endpackage

>>> rtl/quaternion_to_euler_angles_unit.sv
// top level: quaternion to roll, pitch and yaw (z-y-x) in 1/128 degree
// depends on q2e_pkg, q2e_sqrt_cell, q2e_cordic_prep, q2e_cordic_cell
//
// channel   dir  bits  contents
// s_axis    in   64    quat_w, quat_x, quat_y, quat_z (16 bits each, Q1.14)
// m_axis    out  48    roll_angle 16, pitch_angle 15, yaw_angle 16, pad 1
//
// one item per cycle while the output register is empty or taken; each item passes
// through the 29-cell square root chain and the arctangent cell chain.
// rst_ni clears the valid line and the output valid flag.
// the whole pipeline holds while the output register is full and not taken.
module quaternion_to_euler_angles_unit
  import q2e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // roll_angle, pitch_angle, yaw_angle, zero pad
);

  localparam int CtxLen = 3 + SqrtSteps;
  localparam int NumV   = CtxLen + CordicLen + 2;

  logic adv;
  logic [NumV-1:0] vld_q;
  logic out_valid_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NumV-2:0], s_axis_tvalid};
      out_valid_q <= vld_q[NumV-1];
    end
  end

  // products
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [ProdW-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;

  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx_q <= ProdW'(qw) * ProdW'(qx);
      yz_q <= ProdW'(qy) * ProdW'(qz);
      xx_q <= ProdW'(qx) * ProdW'(qx);
      yy_q <= ProdW'(qy) * ProdW'(qy);
      wz_q <= ProdW'(qw) * ProdW'(qz);
      xy_q <= ProdW'(qx) * ProdW'(qy);
      zz_q <= ProdW'(qz) * ProdW'(qz);
      wy_q <= ProdW'(qw) * ProdW'(qy);
      zx_q <= ProdW'(qz) * ProdW'(qx);
    end
  end

  // sums and the clamped arcsine argument
  ctx_t ctx_d;
  ctx_t ctx_q [CtxLen];
  logic signed [SumW:0] rn_s, rd_s, yn_s, yd_s, s_s;

  always_comb begin
    rn_s = ((SumW+1)'(wx_q) + (SumW+1)'(yz_q)) <<< 1;
    yn_s = ((SumW+1)'(wz_q) + (SumW+1)'(xy_q)) <<< 1;
    rd_s = (SumW+1)'(OneQ28) - (((SumW+1)'(xx_q) + (SumW+1)'(yy_q)) <<< 1);
    yd_s = (SumW+1)'(OneQ28) - (((SumW+1)'(yy_q) + (SumW+1)'(zz_q)) <<< 1);
    s_s  = ((SumW+1)'(wy_q) - (SumW+1)'(zx_q)) <<< 1;
    ctx_d.rn = rn_s[SumW-1:0];
    ctx_d.rd = rd_s[SumW-1:0];
    ctx_d.yn = yn_s[SumW-1:0];
    ctx_d.yd = yd_s[SumW-1:0];
    ctx_d.sat_pos = (s_s >= (SumW+1)'(SinMax));
    ctx_d.sat_neg = (s_s <= (SumW+1)'(SinMin));
    if (ctx_d.sat_pos) begin
      ctx_d.s = SinMax;
    end else if (ctx_d.sat_neg) begin
      ctx_d.s = SinMin;
    end else begin
      ctx_d.s = s_s[SinW-1:0];
    end
  end

  // operand delay line beside the square root
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx_q[0] <= ctx_d;
      for (int k = 1; k < CtxLen; k++) begin
        ctx_q[k] <= ctx_q[k-1];
      end
    end
  end

  // square of the argument, then the root operand
  logic [SinW-2:0] s_abs;
  logic [SqW-1:0]  sq_q;
  sqrt_t           sqrt_init_q;
  sqrt_t           sqrt_c [SqrtSteps+1];

  assign s_abs = ctx_q[0].s[SinW-1] ? (SinW-1)'(-ctx_q[0].s) : ctx_q[0].s[SinW-2:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q           <= SqW'(s_abs) * SqW'(s_abs);
      sqrt_init_q.n  <= OneQ56 - sq_q;
      sqrt_init_q.r  <= '0;
      sqrt_init_q.bm <= OneQ56;
    end
  end

  assign sqrt_c[0] = sqrt_init_q;

  // square root chain
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .d_i   (sqrt_c[j]),
      .d_o   (sqrt_c[j+1])
    );
  end

  // arctangent set-up for roll, pitch and yaw
  ctx_t ctx_end;
  logic signed [XW-1:0] cos_x;
  cordic_t roll_c [CordicLen+1];
  cordic_t pit_c  [CordicLen+1];
  cordic_t yaw_c  [CordicLen+1];

  assign ctx_end = ctx_q[CtxLen-1];
  assign cos_x   = $signed({{(XW-RootW){1'b0}}, sqrt_c[SqrtSteps].r[RootW-1:0]});

  q2e_cordic_prep u_prep_roll (
    .clk_i     (clk_i),
    .en_i      (adv),
    .x_i       (XW'(ctx_end.rd)),
    .y_i       (XW'(ctx_end.rn)),
    .pin_i     (1'b0),
    .pin_neg_i (1'b0),
    .d_o       (roll_c[0])
  );

  q2e_cordic_prep u_prep_pitch (
    .clk_i     (clk_i),
    .en_i      (adv),
    .x_i       (cos_x),
    .y_i       (XW'(ctx_end.s)),
    .pin_i     (ctx_end.sat_pos | ctx_end.sat_neg),
    .pin_neg_i (ctx_end.sat_neg),
    .d_o       (pit_c[0])
  );

  q2e_cordic_prep u_prep_yaw (
    .clk_i     (clk_i),
    .en_i      (adv),
    .x_i       (XW'(ctx_end.yd)),
    .y_i       (XW'(ctx_end.yn)),
    .pin_i     (1'b0),
    .pin_neg_i (1'b0),
    .d_o       (yaw_c[0])
  );

  // three arctangent cell chains side by side
  for (genvar i = 0; i < CordicLen; i++) begin : g_cordic
    q2e_cordic_cell u_roll (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (5'(i)),
      .d_i    (roll_c[i]),
      .d_o    (roll_c[i+1])
    );
    q2e_cordic_cell u_pitch (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (5'(i)),
      .d_i    (pit_c[i]),
      .d_o    (pit_c[i+1])
    );
    q2e_cordic_cell u_yaw (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (5'(i)),
      .d_i    (yaw_c[i]),
      .d_o    (yaw_c[i+1])
    );
  end

  // round, clamp and hold the result item
  logic signed [OutW-1:0] roll_r, pitch_r, yaw_r;
  logic [47:0] tdata_q;

  assign roll_r  = round_angle(roll_c[CordicLen].ang, LimWide);
  assign pitch_r = round_angle(pit_c[CordicLen].ang, LimNarrow);
  assign yaw_r   = round_angle(yaw_c[CordicLen].ang, LimWide);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdata_q <= {1'b0, yaw_r[15:0], pitch_r[14:0], roll_r[15:0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tdata_q;

endmodule

>>> rtl/q2e_sqrt_cell.sv
// one cell of the integer square root chain, one root bit per cell
// depends on q2e_pkg
module q2e_sqrt_cell
  import q2e_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t d_i,
  output sqrt_t d_o
);

  sqrt_t d_d, d_q;
  logic [SqW-1:0] trial;

  // trial subtract and root update
  always_comb begin
    trial = d_i.r + d_i.bm;
    d_d   = d_i;
    if (d_i.n >= trial) begin
      d_d.n = d_i.n - trial;
      d_d.r = (d_i.r >> 1) + d_i.bm;
    end else begin
      d_d.r = d_i.r >> 1;
    end
    d_d.bm = d_i.bm >> 2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

>>> rtl/q2e_cordic_prep.sv
// arctangent set-up: special cases and quadrant turn before the cordic cells
// depends on q2e_pkg
module q2e_cordic_prep
  import q2e_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic                 pin_i,
  input  logic                 pin_neg_i,
  output cordic_t              d_o
);

  cordic_t d_d, d_q;

  // pick a pinned angle or turn the vector into the right half plane
  always_comb begin
    d_d.x      = x_i;
    d_d.y      = y_i;
    d_d.ang    = '0;
    d_d.frozen = 1'b0;
    if (pin_i) begin
      d_d.frozen = 1'b1;
      d_d.ang    = pin_neg_i ? -Deg90 : Deg90;
    end else if (x_i == '0 && y_i == '0) begin
      d_d.frozen = 1'b1;
    end else if (x_i < 0 && y_i == '0) begin
      d_d.frozen = 1'b1;
      d_d.ang    = Deg90 <<< 1;
    end else if (x_i < 0) begin
      if (y_i >= 0) begin
        d_d.x   = y_i;
        d_d.y   = -x_i;
        d_d.ang = Deg90;
      end else begin
        d_d.x   = -y_i;
        d_d.y   = x_i;
        d_d.ang = -Deg90;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

>>> rtl/q2e_cordic_cell.sv
// one vectoring cordic micro-rotation, registered
// depends on q2e_pkg
module q2e_cordic_cell
  import q2e_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [4:0] step_i,
  input  cordic_t    d_i,
  output cordic_t    d_o
);

  cordic_t d_d, d_q;
  logic signed [XW-1:0] xs, ys;
  logic signed [AW-1:0] da;

  // rotate toward the x axis
  always_comb begin
    xs  = d_i.x >>> step_i;
    ys  = d_i.y >>> step_i;
    da  = atan_lut(step_i);
    d_d = d_i;
    if (!d_i.frozen) begin
      if (d_i.y > 0) begin
        d_d.x   = d_i.x + ys;
        d_d.y   = d_i.y - xs;
        d_d.ang = d_i.ang + da;
      end else begin
        d_d.x   = d_i.x - ys;
        d_d.y   = d_i.y + xs;
        d_d.ang = d_i.ang - da;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

>>> sim/tb.sv
// self-checking bench for quaternion_to_euler_angles_unit: directed table, then random items
// depends on q2e_pkg (CORDIC_STEPS) and the rtl of the unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import q2e_pkg::*;

  localparam int Latency = 35 + CordicLen;
  localparam int NumRandom = 1680;
  localparam longint CycleLimit = 2_000_000;
  localparam logic signed [63:0] OneQ28L = 64'sd268435456;
  localparam logic signed [63:0] Deg90L = 64'sd5898240;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  // directed row: quaternion, and a typed-in result where it is obvious
  typedef struct {
    quat_t  q;
    bit     fixed;
    euler_t e;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  quaternion_to_euler_angles_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // quat_w, quat_x, quat_y, quat_z
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)    // roll_angle, pitch_angle, yaw_angle, pad
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  euler_t angle_queue[$];
  int     mismatches = 0;
  longint cycles = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_off = 1'b0;
  int     hold_cycles = 0;

  // arithmetic shift right, rounding toward minus infinity
  function automatic logic signed [63:0] shr(input logic signed [63:0] v, input int s);
    return v >>> s;
  endfunction

  function automatic longint atan_tab_val(input int i);
    longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    return tab[i];
  endfunction

  // vectoring arctangent, angle in 1/65536 degree
  function automatic logic signed [63:0] vec_angle(input logic signed [63:0] yy,
                                                   input logic signed [63:0] xx);
    logic signed [63:0] a, t, xs, ys;
    int steps;
    a = 0;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0 && yy == 0) return 2 * Deg90L;
    if (xx < 0) begin
      if (yy >= 0) begin
        t = xx; xx = yy; yy = -t; a = Deg90L;
      end else begin
        t = xx; xx = -yy; yy = t; a = -Deg90L;
      end
    end
    for (int i = 0; i < steps; i++) begin
      xs = shr(xx, i);
      ys = shr(yy, i);
      if (yy > 0) begin
        xx = xx + ys; yy = yy - xs; a = a + 64'(atan_tab_val(i));
      end else begin
        xx = xx - ys; yy = yy + xs; a = a - 64'(atan_tab_val(i));
      end
    end
    return a;
  endfunction

  function automatic longint to_deg128(input logic signed [63:0] a, input longint lim);
    longint d;
    d = shr(a + 256, 9);
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return d;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // expected euler angles for one quaternion
  function automatic euler_t quat_to_euler(input quat_t q);
    logic signed [63:0] w, x, y, z, s, c;
    logic [63:0] sq;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    e.roll = 16'(to_deg128(vec_angle(2 * (w * x + y * z),
                                     OneQ28L - 2 * (x * x + y * y)), 23040));
    e.yaw = 16'(to_deg128(vec_angle(2 * (w * z + x * y),
                                    OneQ28L - 2 * (y * y + z * z)), 23040));
    s = 2 * (w * y - z * x);
    if (s > OneQ28L) s = OneQ28L;
    if (s < -OneQ28L) s = -OneQ28L;
    if (s == OneQ28L) begin
      e.pitch = 15'sd11520;
    end else if (s == -OneQ28L) begin
      e.pitch = -15'sd11520;
    end else begin
      sq = (s < 0) ? -s : s;
      c = floor_sqrt((64'd1 << 56) - sq * sq);
      e.pitch = 15'(to_deg128(vec_angle(s, c), 11520));
    end
    return e;
  endfunction

  // send one quaternion and record its expectation
  task automatic send_quat(input quat_t q, input bit fixed, input euler_t e);
    while (!hold_off && send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {q.z, q.y, q.x, q.w};
    angle_queue.push_back(fixed ? e : quat_to_euler(q));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rnd_comp();
    case ($urandom_range(5))
      0: return 16'(int'($urandom_range(32768)) - 16384);
      1: return 16'($urandom);
      2: return 16'sd16384;
      3: return -16'sd16384;
      default: return 16'(int'($urandom_range(4000)) - 2000);
    endcase
  endfunction

  // random quaternion, mostly close to unit length
  function automatic quat_t rnd_quat();
    quat_t q;
    real a, b, c, d, n;
    if ($urandom_range(3) == 0) begin
      q.w = rnd_comp(); q.x = rnd_comp(); q.y = rnd_comp(); q.z = rnd_comp();
    end else begin
      a = real'(int'($urandom_range(2000)) - 1000);
      b = real'(int'($urandom_range(2000)) - 1000);
      c = real'(int'($urandom_range(2000)) - 1000);
      d = real'(int'($urandom_range(2000)) - 1000);
      if ($urandom_range(4) == 0) d = 0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) n = 1.0;
      q.w = 16'($rtoi(16384.0 * a / n)); q.x = 16'($rtoi(16384.0 * b / n));
      q.y = 16'($rtoi(16384.0 * c / n)); q.z = 16'($rtoi(16384.0 * d / n));
    end
    return q;
  endfunction

  // result checker against the oldest expectation
  always @(posedge clk_i) begin
    euler_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.roll  = m_axis_tdata[15:0];
      got.pitch = m_axis_tdata[30:16];
      got.yaw   = m_axis_tdata[46:31];
      if (angle_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", got);
      end else begin
        want = angle_queue.pop_front();
        if (got.roll !== want.roll || got.pitch !== want.pitch || got.yaw !== want.yaw
            || m_axis_tdata[47] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch roll %0d/%0d pitch %0d/%0d yaw %0d/%0d",
                     want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw);
        end
      end
    end
  end

  // receiver stalls, with a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_off && hold_cycles < 300) begin
      hold_cycles <= hold_cycles + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    int   phase_len;
    r.fixed = 1'b1;
    // identity, zero vector, pitch close to 90 degrees
    r.q = '{16384, 0, 0, 0};           r.e = '{0, 0, 0};           rows.push_back(r);
    r.q = '{0, 0, 0, 0};               r.e = '{0, 0, 0};           rows.push_back(r);
    r.q = '{11585, 0, 11585, 0};       r.fixed = 0;                rows.push_back(r);
    r.fixed = 1'b1;
    // off-sphere pitch clamps also flip roll and yaw to 180 degrees
    r.q = '{16384, 0, 16384, 0};       r.e = '{23040, 11520, 23040};  rows.push_back(r);
    r.q = '{16384, 0, -16384, 0};      r.e = '{23040, -11520, 23040}; rows.push_back(r);
    r.fixed = 1'b0;
    // 180 degree turns about x, z and y: negative denominator with zero numerator
    r.q = '{0, 16384, 0, 0};           rows.push_back(r);
    r.q = '{0, 0, 0, 16384};           rows.push_back(r);
    r.q = '{0, 0, 16384, 0};           rows.push_back(r);
    // negative x operand, both signs of y
    r.q = '{4000, 15000, 0, 0};        rows.push_back(r);
    r.q = '{-4000, 15000, 0, 0};       rows.push_back(r);
    r.q = '{4000, 0, 0, 15000};        rows.push_back(r);
    r.q = '{-4000, 0, 0, 15000};       rows.push_back(r);
    // field extremes and off-sphere inputs
    r.q = '{-16384, -16384, -16384, -16384}; rows.push_back(r);
    r.q = '{16384, 16384, 16384, 16384};     rows.push_back(r);
    r.q = '{32767, -32768, 32767, -32768};   rows.push_back(r);
    r.q = '{-32768, 32767, -32768, 32767};   rows.push_back(r);
    r.q = '{-1, -1, -1, -1};           rows.push_back(r);
    r.q = '{8192, 8192, 8192, 8192};   rows.push_back(r);
    r.q = '{8192, -8192, 8192, -8192}; rows.push_back(r);
    r.q = '{16000, 1000, -2000, 3000}; rows.push_back(r);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_quat(rows[i].q, rows[i].fixed, rows[i].e);
    wait_drained();

    // long receiver hold-off while items keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++) send_quat(rnd_quat(), 1'b0, '0);
    hold_off = 1'b0;
    wait_drained();

    // idling phases
    phase_len = NumRandom / 4;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 27) : 0;
      recv_stall_pct = (ph == 2) ? 74 : ((ph == 3) ? 27 : 0);
      for (int i = 0; i < phase_len; i++) send_quat(rnd_quat(), 1'b0, '0);
      wait_drained();
    end

    if (mismatches == 0 && angle_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/q2e_pkg.sv
rtl/q2e_sqrt_cell.sv
rtl/q2e_cordic_prep.sv
rtl/q2e_cordic_cell.sv
rtl/quaternion_to_euler_angles_unit.sv
sim/tb.sv
